/* hdl/hsv2rgb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

  // Fixed scales of the conversion
  localparam int HueSectorDeg = 60;
  localparam int FullScale    = 255;
  localparam int SectorScale  = HueSectorDeg * FullScale;  // 15300
  localparam int NumThresh    = 8;                         // 60..480 covers 0..511

  // Reciprocal of SectorScale; the estimate is low by at most one
  localparam int RecipShift = 30;
  localparam int RecipMul   = (1 << RecipShift) / SectorScale;

  typedef logic [8:0]  hue_t;     // hue angle
  typedef logic [7:0]  chan_t;    // 8-bit channel
  typedef logic [5:0]  rem_t;     // hue mod 60
  typedef logic [3:0]  sec_cnt_t; // full sector 0..8
  typedef logic [13:0] prod_t;    // s * rem, up to 15045
  typedef logic [15:0] pnum_t;    // v * (255 - s)
  typedef logic [21:0] tnum_t;    // v * (15300 - s*rem)
  typedef logic [16:0] recip_t;   // reciprocal constant
  typedef logic [38:0] est_t;     // tnum_t * recip_t

  // Sector row of the placement table; hue of 300 and up uses the last row
  typedef enum logic [2:0] {
    SECT_RED_TO_YEL  = 3'd0,
    SECT_YEL_TO_GRN  = 3'd1,
    SECT_GRN_TO_CYN  = 3'd2,
    SECT_CYN_TO_BLU  = 3'd3,
    SECT_BLU_TO_MAG  = 3'd4,
    SECT_MAG_TO_RED  = 3'd5
  } sector_e;

endpackage

`default_nettype wire

/* hdl/hsv_to_rgb_converter_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// HSV to 8-bit RGB converter. Takes one pixel per clock: an item is taken at
// every edge with start_i high (busy_o is always low, the pipeline never
// stalls) and its red/green/blue come out on red_o/green_o/blue_o with done_o
// high for a single cycle. The receiver cannot hold results off; a result not
// taken in its done_o cycle is gone. The pipeline has six register stages:
// sector split, three small products, the two wide term products, the
// reciprocal multiply for the divide by 15300, its one-step correction, and
// the sector placement. Hue 360..511 uses the magenta-to-red row; zero
// saturation gives grey because all three terms then reduce to the value.
module hsv_to_rgb_converter_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output logic      busy_o,
  input  wire logic [8:0] hue_i,
  input  wire logic [7:0] saturation_i,
  input  wire logic [7:0] brightness_i,
  output logic      done_o,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o
);

  // Fully pipelined, nothing ever backs up
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i & ~busy_o;

  // ---------------------------------------------------------------------
  // Stage 1: sector = hue div 60, rem = hue mod 60
  // ---------------------------------------------------------------------
  hsv2rgb_pkg::sec_cnt_t sec_full;
  hsv2rgb_pkg::hue_t     sec_base;
  hsv2rgb_pkg::sector_e  s1_sector_d, s1_sector_q;
  hsv2rgb_pkg::rem_t     s1_rem_d, s1_rem_q;
  hsv2rgb_pkg::chan_t    s1_sat_q, s1_val_q;
  logic                  s1_vld_q;

  always_comb begin
    sec_full = '0;
    for (int i = 1; i <= hsv2rgb_pkg::NumThresh; i++) begin
      if (hue_i >= hsv2rgb_pkg::hue_t'(i * hsv2rgb_pkg::HueSectorDeg)) begin
        sec_full = sec_full + hsv2rgb_pkg::sec_cnt_t'(1);
      end
    end
    sec_base = hsv2rgb_pkg::hue_t'(sec_full) *
               hsv2rgb_pkg::hue_t'(hsv2rgb_pkg::HueSectorDeg);
    s1_rem_d = hsv2rgb_pkg::rem_t'(hue_i - sec_base);
    if (sec_full > hsv2rgb_pkg::sec_cnt_t'(hsv2rgb_pkg::SECT_MAG_TO_RED)) begin
      s1_sector_d = hsv2rgb_pkg::SECT_MAG_TO_RED;
    end else begin
      s1_sector_d = hsv2rgb_pkg::sector_e'(sec_full[2:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sector_q <= s1_sector_d;
    s1_rem_q    <= s1_rem_d;
    s1_sat_q    <= saturation_i;
    s1_val_q    <= brightness_i;
  end

  // ---------------------------------------------------------------------
  // Stage 2: s*rem, s*(60-rem), v*(255-s)
  // ---------------------------------------------------------------------
  hsv2rgb_pkg::prod_t   s2_srem_q, s2_scomp_q;
  hsv2rgb_pkg::pnum_t   s2_pnum_q;
  hsv2rgb_pkg::sector_e s2_sector_q;
  hsv2rgb_pkg::chan_t   s2_val_q;
  logic                 s2_vld_q;

  always_ff @(posedge clk_i) begin
    s2_srem_q   <= hsv2rgb_pkg::prod_t'(s1_sat_q) * hsv2rgb_pkg::prod_t'(s1_rem_q);
    s2_scomp_q  <= hsv2rgb_pkg::prod_t'(s1_sat_q) *
                   (hsv2rgb_pkg::prod_t'(hsv2rgb_pkg::HueSectorDeg) -
                    hsv2rgb_pkg::prod_t'(s1_rem_q));
    s2_pnum_q   <= hsv2rgb_pkg::pnum_t'(s1_val_q) *
                   (hsv2rgb_pkg::pnum_t'(hsv2rgb_pkg::FullScale) -
                    hsv2rgb_pkg::pnum_t'(s1_sat_q));
    s2_sector_q <= s1_sector_q;
    s2_val_q    <= s1_val_q;
  end

  // ---------------------------------------------------------------------
  // Stage 3: q/t numerators, p = floor(pnum/255) by add-and-shift
  // ---------------------------------------------------------------------
  hsv2rgb_pkg::pnum_t   p_sum;
  hsv2rgb_pkg::tnum_t   s3_qnum_q, s3_tnum_q;
  hsv2rgb_pkg::chan_t   s3_p_q, s3_val_q;
  hsv2rgb_pkg::sector_e s3_sector_q;
  logic                 s3_vld_q;

  // exact for numerators up to 255*255
  assign p_sum = s2_pnum_q + (s2_pnum_q >> 8) + hsv2rgb_pkg::pnum_t'(1);

  always_ff @(posedge clk_i) begin
    s3_qnum_q   <= hsv2rgb_pkg::tnum_t'(s2_val_q) *
                   (hsv2rgb_pkg::tnum_t'(hsv2rgb_pkg::SectorScale) -
                    hsv2rgb_pkg::tnum_t'(s2_srem_q));
    s3_tnum_q   <= hsv2rgb_pkg::tnum_t'(s2_val_q) *
                   (hsv2rgb_pkg::tnum_t'(hsv2rgb_pkg::SectorScale) -
                    hsv2rgb_pkg::tnum_t'(s2_scomp_q));
    s3_p_q      <= p_sum[15:8];
    s3_val_q    <= s2_val_q;
    s3_sector_q <= s2_sector_q;
  end

  // ---------------------------------------------------------------------
  // Stage 4: reciprocal estimate of num/15300 (low by 0 or 1)
  // ---------------------------------------------------------------------
  hsv2rgb_pkg::est_t    q_prod, t_prod;
  hsv2rgb_pkg::chan_t   s4_qest_q, s4_test_q, s4_p_q, s4_val_q;
  hsv2rgb_pkg::tnum_t   s4_qnum_q, s4_tnum_q;
  hsv2rgb_pkg::sector_e s4_sector_q;
  logic                 s4_vld_q;

  assign q_prod = hsv2rgb_pkg::est_t'(s3_qnum_q) *
                  hsv2rgb_pkg::est_t'(hsv2rgb_pkg::recip_t'(hsv2rgb_pkg::RecipMul));
  assign t_prod = hsv2rgb_pkg::est_t'(s3_tnum_q) *
                  hsv2rgb_pkg::est_t'(hsv2rgb_pkg::recip_t'(hsv2rgb_pkg::RecipMul));

  always_ff @(posedge clk_i) begin
    s4_qest_q   <= q_prod[hsv2rgb_pkg::RecipShift +: 8];
    s4_test_q   <= t_prod[hsv2rgb_pkg::RecipShift +: 8];
    s4_qnum_q   <= s3_qnum_q;
    s4_tnum_q   <= s3_tnum_q;
    s4_p_q      <= s3_p_q;
    s4_val_q    <= s3_val_q;
    s4_sector_q <= s3_sector_q;
  end

  // ---------------------------------------------------------------------
  // Stage 5: correct estimate by one where the remainder is still >= 15300
  // ---------------------------------------------------------------------
  hsv2rgb_pkg::tnum_t   q_rem, t_rem;
  hsv2rgb_pkg::chan_t   q_fix, t_fix;
  hsv2rgb_pkg::chan_t   s5_q_q, s5_t_q, s5_p_q, s5_val_q;
  hsv2rgb_pkg::sector_e s5_sector_q;
  logic                 s5_vld_q;

  always_comb begin
    q_rem = s4_qnum_q - hsv2rgb_pkg::tnum_t'(s4_qest_q) *
                        hsv2rgb_pkg::tnum_t'(hsv2rgb_pkg::SectorScale);
    t_rem = s4_tnum_q - hsv2rgb_pkg::tnum_t'(s4_test_q) *
                        hsv2rgb_pkg::tnum_t'(hsv2rgb_pkg::SectorScale);
    q_fix = s4_qest_q;
    t_fix = s4_test_q;
    if (q_rem >= hsv2rgb_pkg::tnum_t'(hsv2rgb_pkg::SectorScale)) begin
      q_fix = s4_qest_q + hsv2rgb_pkg::chan_t'(1);
    end
    if (t_rem >= hsv2rgb_pkg::tnum_t'(hsv2rgb_pkg::SectorScale)) begin
      t_fix = s4_test_q + hsv2rgb_pkg::chan_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    s5_q_q      <= q_fix;
    s5_t_q      <= t_fix;
    s5_p_q      <= s4_p_q;
    s5_val_q    <= s4_val_q;
    s5_sector_q <= s4_sector_q;
  end

  // ---------------------------------------------------------------------
  // Stage 6: place v/p/q/t by sector into the output registers
  // ---------------------------------------------------------------------
  hsv2rgb_pkg::chan_t red_d, green_d, blue_d;
  hsv2rgb_pkg::chan_t red_q, green_q, blue_q;
  logic               done_q;

  always_comb begin
    unique case (s5_sector_q)
      hsv2rgb_pkg::SECT_RED_TO_YEL: begin
        red_d = s5_val_q; green_d = s5_t_q;   blue_d = s5_p_q;
      end
      hsv2rgb_pkg::SECT_YEL_TO_GRN: begin
        red_d = s5_q_q;   green_d = s5_val_q; blue_d = s5_p_q;
      end
      hsv2rgb_pkg::SECT_GRN_TO_CYN: begin
        red_d = s5_p_q;   green_d = s5_val_q; blue_d = s5_t_q;
      end
      hsv2rgb_pkg::SECT_CYN_TO_BLU: begin
        red_d = s5_p_q;   green_d = s5_q_q;   blue_d = s5_val_q;
      end
      hsv2rgb_pkg::SECT_BLU_TO_MAG: begin
        red_d = s5_t_q;   green_d = s5_p_q;   blue_d = s5_val_q;
      end
      default: begin
        red_d = s5_val_q; green_d = s5_p_q;   blue_d = s5_q_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
  end

  // Valid bits travel alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      done_q   <= s5_vld_q;
    end
  end

  assign done_o  = done_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps

// HSV to RGB converter bench. A driver pulls pixels from a pending queue,
// a monitor predicts red/green/blue for every pixel the block takes and
// compares each done_o result against the oldest prediction.
module tb_top;
  import hsv2rgb_pkg::*;

  localparam int unsigned DEG_PER_SECTOR = 60;
  localparam int unsigned CHAN_FULL      = 255;
  localparam int          NUM_RANDOM     = 600;
  localparam int          CYCLE_LIMIT    = 50000;
  // Points, in pixels launched, where the driver waits for the pipe to drain
  localparam int          DRAIN_AT_A     = 22;
  localparam int          DRAIN_AT_B     = 380;
  // Window, in pixels launched, with back-to-back items only
  localparam int          BURST_LO       = 150;
  localparam int          BURST_HI       = 330;

  typedef struct packed {
    hue_t  hue;
    chan_t sat;
    chan_t val;
  } hsv_pix_t;

  typedef struct packed {
    hsv_pix_t pix;
    chan_t    red;
    chan_t    green;
    chan_t    blue;
  } rgb_want_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       start_i      = 1'b0;
  hue_t       hue_i        = '0;
  chan_t      saturation_i = '0;
  chan_t      brightness_i = '0;
  logic       busy_o;
  logic       done_o;
  logic [7:0] red_o;
  logic [7:0] green_o;
  logic [7:0] blue_o;

  hsv_pix_t  pix_q[$];      // pixels still to be sent
  rgb_want_t rgb_want_q[$]; // predicted colors, oldest first
  int        n_total;
  int        n_launched;
  int        n_accepted;
  int        n_checked;
  int        n_err;
  int        n_cycles;

  hsv_to_rgb_converter_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .hue_i       (hue_i),
    .saturation_i(saturation_i),
    .brightness_i(brightness_i),
    .done_o      (done_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Exact integer HSV->RGB, terms rounded down, six-row placement table.
  function automatic rgb_want_t hsv_to_rgb(hue_t h, chan_t s, chan_t v);
    rgb_want_t   c;
    int unsigned si;
    int unsigned vi;
    int unsigned span;
    int unsigned sec;
    int unsigned rem;
    int unsigned p;
    int unsigned q;
    int unsigned t;
    sector_e     row;
    si   = s;
    vi   = v;
    span = DEG_PER_SECTOR * CHAN_FULL;
    c.pix.hue = h;
    c.pix.sat = s;
    c.pix.val = v;
    if (si == 0) begin
      // grey: no hue at all
      c.red   = v;
      c.green = v;
      c.blue  = v;
    end else begin
      sec = h / DEG_PER_SECTOR;
      rem = h % DEG_PER_SECTOR;
      p = (vi * (CHAN_FULL - si)) / CHAN_FULL;
      q = (vi * (span - si * rem)) / span;
      t = (vi * (span - si * (DEG_PER_SECTOR - rem))) / span;
      // hue 300 and up, including 360..511, stays on the last row
      row = (sec >= 5) ? SECT_MAG_TO_RED : sector_e'(sec);
      case (row)
        SECT_RED_TO_YEL: begin
          c.red = v;          c.green = chan_t'(t); c.blue = chan_t'(p);
        end
        SECT_YEL_TO_GRN: begin
          c.red = chan_t'(q); c.green = v;          c.blue = chan_t'(p);
        end
        SECT_GRN_TO_CYN: begin
          c.red = chan_t'(p); c.green = v;          c.blue = chan_t'(t);
        end
        SECT_CYN_TO_BLU: begin
          c.red = chan_t'(p); c.green = chan_t'(q); c.blue = v;
        end
        SECT_BLU_TO_MAG: begin
          c.red = chan_t'(t); c.green = chan_t'(p); c.blue = v;
        end
        default: begin
          c.red = v;          c.green = chan_t'(p); c.blue = chan_t'(q);
        end
      endcase
    end
    return c;
  endfunction

  task automatic queue_pixel(int h, int s, int v);
    hsv_pix_t px;
    px.hue = hue_t'(h);
    px.sat = chan_t'(s);
    px.val = chan_t'(v);
    pix_q.push_back(px);
  endtask

  // Channel value leaning on the ends of the range now and then
  function automatic chan_t pick_chan();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 7)
      return 8'd0;
    else if (r < 14)
      return 8'd255;
    else
      return chan_t'($urandom_range(255));
  endfunction

  // Driver: a new item may go out once the current one has been taken.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    hsv_pix_t px;
    logic     launch;
    logic     drain_hold;
    logic     idle;
    if (!rst_ni) begin
      start_i      <= 1'b0;
      hue_i        <= '0;
      saturation_i <= '0;
      brightness_i <= '0;
      n_launched   <= 0;
    end else if (!start_i || !busy_o) begin
      // hold at the drain points until every launched item has come back
      drain_hold = (n_launched == DRAIN_AT_A || n_launched == DRAIN_AT_B) &&
                   (n_checked != n_launched);
      idle = !(n_launched >= BURST_LO && n_launched < BURST_HI) &&
             ($urandom_range(99) < 22);
      launch = (pix_q.size() != 0) && !drain_hold && !idle;
      if (launch) begin
        px = pix_q.pop_front();
        hue_i        <= px.hue;
        saturation_i <= px.sat;
        brightness_i <= px.val;
        n_launched   <= n_launched + 1;
      end
      start_i <= launch;
    end
  end

  // Monitor: prediction on take, compare on done_o. Both in one process so
  // a short latency cannot race the push against the pop.
  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    rgb_want_t want;
    if (!rst_ni) begin
      n_accepted <= 0;
      n_checked  <= 0;
    end else begin
      if (start_i && !busy_o) begin
        rgb_want_q.push_back(hsv_to_rgb(hue_i, saturation_i, brightness_i));
        n_accepted <= n_accepted + 1;
      end
      if (done_o) begin
        if (rgb_want_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got r=%0d g=%0d b=%0d",
                   $realtime, red_o, green_o, blue_o);
          n_err++;
        end else begin
          want = rgb_want_q.pop_front();
          n_checked <= n_checked + 1;
          if (red_o !== want.red) begin
            $display("%0t: red mismatch for hsv %0d/%0d/%0d, expected %0d, got %0d",
                     $realtime, want.pix.hue, want.pix.sat, want.pix.val, want.red, red_o);
            n_err++;
          end
          if (green_o !== want.green) begin
            $display("%0t: green mismatch for hsv %0d/%0d/%0d, expected %0d, got %0d",
                     $realtime, want.pix.hue, want.pix.sat, want.pix.val, want.green,
                     green_o);
            n_err++;
          end
          if (blue_o !== want.blue) begin
            $display("%0t: blue mismatch for hsv %0d/%0d/%0d, expected %0d, got %0d",
                     $realtime, want.pix.hue, want.pix.sat, want.pix.val, want.blue, blue_o);
            n_err++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $realtime, rgb_want_q.size());
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin : stim_proc
    hsv_pix_t    px;
    int unsigned r;
    n_err    = 0;
    n_cycles = 0;

    // Directed: sector edges, full scale, grey, black, hue 360 and above
    queue_pixel(0,   255, 255);
    queue_pixel(59,  255, 255);  // largest s*rem
    queue_pixel(60,  255, 255);
    queue_pixel(119, 200, 180);
    queue_pixel(120, 255, 255);
    queue_pixel(179, 128, 255);
    queue_pixel(180, 255, 255);
    queue_pixel(240, 255, 255);
    queue_pixel(299, 255, 200);
    queue_pixel(300, 255, 255);
    queue_pixel(359, 255, 255);
    queue_pixel(360, 255, 255);  // wraps to last row, remainder 0
    queue_pixel(360, 100, 77);
    queue_pixel(361, 255, 255);  // beyond a full turn
    queue_pixel(420, 180, 200);
    queue_pixel(480, 255, 255);
    queue_pixel(511, 255, 255);
    queue_pixel(123, 0,   200);  // grey
    queue_pixel(511, 0,   255);
    queue_pixel(200, 255, 0);    // black
    queue_pixel(30,  1,   255);
    queue_pixel(90,  254, 1);
    queue_pixel(256, 170, 85);

    // Random: mostly real hues, some out past 360
    repeat (NUM_RANDOM) begin
      r = $urandom_range(99);
      px.hue = (r < 12) ? hue_t'($urandom_range(511, 361)) : hue_t'($urandom_range(360));
      px.sat = pick_chan();
      px.val = pick_chan();
      pix_q.push_back(px);
    end
    n_total = pix_q.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (n_accepted == n_total);
    wait (rgb_want_q.size() == 0);
    // catch any stray result trailing the last one
    repeat (20) @(posedge clk_i);

    if (n_err == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
